>>> hw/rtl/w2s_pkg.sv
// Shared types and constants for the world-to-screen projection block.
package w2s_pkg;

    // Input word action codes.
    typedef enum logic [1:0] {
        ACT_LOAD_P  = 2'd0,
        ACT_LOAD_V  = 2'd1,
        ACT_PROJECT = 2'd2,
        ACT_NOP     = 2'd3
    } action_t;

    // Configuration register indexes.
    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam int SCREEN_W  = 14;
    localparam int FIELD_W   = 32;
    localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 14'd1920;
    localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 14'd1080;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VP_RD,
        ST_VP_MUL,
        ST_VP_ACC,
        ST_CL_MUL,
        ST_CL_ACC,
        ST_CHECK,
        ST_DIV,
        ST_SCR_MUL,
        ST_SCR_WR,
        ST_OUT
    } state_t;

    // Divider start and status between sequencer and divider.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

>>> hw/rtl/world_to_screen_projection_unit.sv
// Top level: world-to-screen projection with a shared multiplier and divider.
// Load words are taken while idle. A project word runs P*V through the registered shared
// multiplier, then the clip coordinates, the checks, two serial divides and the screen
// mapping; a rejected point skips the divides and the mapping and gives a zero result.
// The next word is taken only once the result has been accepted and the sequencer is idle.
// Reset (aresetn low, synchronous) clears both matrices and sets 1920x1080.
module world_to_screen_projection_unit #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] action, [3:2] matrix_row, [5:4] matrix_col, [37:6] coefficient,
    // [69:38] world_x, [101:70] world_y, [133:102] world_z, [135:134] zero
    input  logic [135:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] visible, [32:1] screen_x, [64:33] screen_y, [71:65] zero
    output logic [71:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [13:0] cfg_data
);
    localparam int DW = DATA_WIDTH;
    localparam int FW = w2s_pkg::FIELD_W;
    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW+2:0] W_MIN = (DW+3)'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic signed [DW+2:0] ONE   = (DW+3)'(1 << FRAC_BITS);
    localparam int SW = w2s_pkg::SCREEN_W;

    // Field extraction.
    w2s_pkg::action_t act;
    logic [3:0]       in_idx;
    assign act    = w2s_pkg::action_t'(s_tdata[1:0]);
    assign in_idx = {s_tdata[3:2], s_tdata[5:4]};

    function automatic logic signed [DW-1:0] sat_field(input logic [FW-1:0] v);
        logic signed [63:0] s;
        s = 64'(signed'(v));
        if (s > 64'(VMAX)) return VMAX;
        if (s < 64'(VMIN)) return VMIN;
        return s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sat_acc(input logic signed [DW+2:0] v);
        if (v > (DW+3)'(VMAX)) return VMAX;
        if (v < (DW+3)'(VMIN)) return VMIN;
        return v[DW-1:0];
    endfunction

    // State.
    logic signed [DW-1:0] pm_reg [16];
    logic signed [DW-1:0] vm_reg [16];
    logic signed [DW-1:0] vp_reg [16];
    logic signed [DW-1:0] pt_reg [3];
    logic signed [DW-1:0] clip_reg [4];
    logic [SW-1:0] sw_reg, sh_reg;
    w2s_pkg::state_t st_reg, st_next;
    logic [3:0] i_reg, i_next;       // output element
    logic [1:0] k_reg, k_next;       // term
    logic       ax_reg, ax_next;     // divide axis
    logic signed [DW+2:0] acc_reg, acc_next;
    logic [DW+1:0] nx_reg, ny_reg;
    logic [71:0] out_reg;
    logic        out_valid_reg;

    // Shared multiplier operands.
    logic signed [DW-1:0] ma, mb, mp;
    w2s_qmul #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DW)) u_mul (
        .aclk(aclk), .a(ma), .b(mb), .p(mp)
    );

    // Shared divider.
    w2s_pkg::div_ctl_t dctl_in, dctl_out;
    logic [DW-1:0] dnum;
    logic [DW+1:0] dquo;
    w2s_div #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ctl_in(dctl_in), .ctl_out(dctl_out),
        .num(dnum), .den(clip_reg[3]), .quo(dquo)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        ma = '0;
        mb = '0;
        case (st_reg)
            w2s_pkg::ST_VP_RD, w2s_pkg::ST_VP_MUL: begin
                ma = pm_reg[{i_reg[3:2], k_reg}];
                mb = vm_reg[{k_reg, i_reg[1:0]}];
            end
            w2s_pkg::ST_CL_MUL, w2s_pkg::ST_CL_ACC: begin
                ma = pt_reg[k_reg];
                mb = vp_reg[{k_reg, i_reg[1:0]}];
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // Absolute clip values and checks.
    logic [DW-1:0] ax0, ax1, ax2;
    logic          reject;
    logic signed [DW+2:0] w3;
    assign ax0 = clip_reg[0][DW-1] ? DW'(-clip_reg[0]) : clip_reg[0];
    assign ax1 = clip_reg[1][DW-1] ? DW'(-clip_reg[1]) : clip_reg[1];
    assign ax2 = clip_reg[2][DW-1] ? DW'(-clip_reg[2]) : clip_reg[2];
    assign w3  = (DW+3)'(clip_reg[3]);
    always_comb begin
        reject = (w3 < W_MIN)
              || ({ax0, 1'b0} > (DW+1)'(3 * w3))
              || ({ax1, 1'b0} > (DW+1)'(3 * w3))
              || ((DW+1)'(ax2) > (DW+1)'(w3));
    end
    // The numerator follows the axis that the divider starts on.
    assign dnum = ax_next ? ax1 : ax0;

    // Screen mapping: one multiply of screen size by (1 +/- ndc) per axis.
    logic signed [DW+2:0] nxs, nys, fx, fy;
    logic signed [DW+SW+3:0] px, py, hx, hy;
    assign nxs = clip_reg[0][DW-1] ? -(DW+3)'(nx_reg) : (DW+3)'(nx_reg);
    assign nys = clip_reg[1][DW-1] ? -(DW+3)'(ny_reg) : (DW+3)'(ny_reg);
    assign fx  = ONE + nxs;
    assign fy  = ONE - nys;
    logic signed [DW+SW+3:0] prx_reg, pry_reg;
    assign hx = prx_reg >>> 1;
    assign hy = pry_reg >>> 1;
    function automatic logic signed [FW-1:0] sat_out(input logic signed [DW+SW+3:0] v);
        if (v > (DW+SW+4)'(32'sh7fffffff)) return 32'sh7fffffff;
        if (v < -(DW+SW+4)'(64'sh80000000)) return 32'sh80000000;
        return v[FW-1:0];
    endfunction
    assign px = (DW+SW+4)'(fx) * (DW+SW+4)'(signed'({1'b0, sw_reg}));
    assign py = (DW+SW+4)'(fy) * (DW+SW+4)'(signed'({1'b0, sh_reg}));

    // Next-state logic.
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            w2s_pkg::ST_IDLE:
                if (s_tvalid && act == w2s_pkg::ACT_PROJECT) st_next = w2s_pkg::ST_VP_RD;
            w2s_pkg::ST_VP_RD:  st_next = w2s_pkg::ST_VP_MUL;
            w2s_pkg::ST_VP_MUL: st_next = w2s_pkg::ST_VP_ACC;
            w2s_pkg::ST_VP_ACC:
                if (k_reg == 2'd3 && i_reg == 4'd15) st_next = w2s_pkg::ST_CL_MUL;
                else st_next = w2s_pkg::ST_VP_RD;
            w2s_pkg::ST_CL_MUL: st_next = w2s_pkg::ST_CL_ACC;
            w2s_pkg::ST_CL_ACC:
                if (k_reg == 2'd2 && i_reg == 4'd3) st_next = w2s_pkg::ST_CHECK;
                else st_next = w2s_pkg::ST_CL_MUL;
            w2s_pkg::ST_CHECK:  st_next = reject ? w2s_pkg::ST_OUT : w2s_pkg::ST_DIV;
            w2s_pkg::ST_DIV:
                if (dctl_out.done && ax_reg) st_next = w2s_pkg::ST_SCR_MUL;
            w2s_pkg::ST_SCR_MUL: st_next = w2s_pkg::ST_SCR_WR;
            w2s_pkg::ST_SCR_WR:  st_next = w2s_pkg::ST_OUT;
            w2s_pkg::ST_OUT:
                if (!out_valid_reg) st_next = w2s_pkg::ST_IDLE;
            default: st_next = w2s_pkg::ST_IDLE;
        endcase
    end

    // Running sums for the matrix product and the clip coordinates.
    logic signed [DW+2:0] vp_sum, cl_sum, cl_base;
    assign vp_sum  = acc_reg + (DW+3)'(mp);
    assign cl_base = (DW+3)'(vp_reg[{2'd3, i_reg[1:0]}]);
    assign cl_sum  = (k_reg == 2'd0 ? cl_base : acc_reg) + (DW+3)'(mp);

    // Counter and accumulator logic.
    always_comb begin
        i_next   = i_reg;
        k_next   = k_reg;
        ax_next  = ax_reg;
        acc_next = acc_reg;
        dctl_in  = '0;
        case (st_reg)
            w2s_pkg::ST_IDLE: begin
                i_next   = '0;
                k_next   = '0;
                ax_next  = 1'b0;
                acc_next = '0;
            end
            w2s_pkg::ST_VP_ACC: begin
                if (k_reg == 2'd3) begin
                    acc_next = '0;
                    i_next   = i_reg + 1'b1;
                    k_next   = '0;
                    if (i_reg == 4'd15) begin
                        i_next   = '0;
                        acc_next = '0;
                    end
                end else begin
                    acc_next = acc_reg + (DW+3)'(mp);
                    k_next   = k_reg + 1'b1;
                end
            end
            w2s_pkg::ST_CL_ACC: begin
                if (k_reg == 2'd2) begin
                    i_next   = i_reg + 1'b1;
                    k_next   = '0;
                end else begin
                    acc_next = cl_sum;
                    k_next   = k_reg + 1'b1;
                end
            end
            w2s_pkg::ST_CHECK: dctl_in.start = !reject;
            w2s_pkg::ST_DIV: begin
                if (dctl_out.done && !ax_reg) begin
                    ax_next       = 1'b1;
                    dctl_in.start = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Output and handshake logic.
    assign s_tready  = (st_reg == w2s_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= w2s_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            sw_reg        <= w2s_pkg::WIDTH_RESET;
            sh_reg        <= w2s_pkg::HEIGHT_RESET;
            for (int n = 0; n < 16; n++) begin
                pm_reg[n] <= '0;
                vm_reg[n] <= '0;
            end
        end else begin
            st_reg <= st_next;
            if (cfg_valid) begin
                if (cfg_index == w2s_pkg::CFG_WIDTH) sw_reg <= cfg_data;
                else sh_reg <= cfg_data;
            end
            if (s_tvalid && s_tready && act == w2s_pkg::ACT_LOAD_P)
                pm_reg[in_idx] <= sat_field(s_tdata[37:6]);
            if (s_tvalid && s_tready && act == w2s_pkg::ACT_LOAD_V)
                vm_reg[in_idx] <= sat_field(s_tdata[37:6]);
            if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            if ((st_reg == w2s_pkg::ST_CHECK && reject) || st_reg == w2s_pkg::ST_SCR_WR)
                out_valid_reg <= 1'b1;
        end
        i_reg   <= i_next;
        k_reg   <= k_next;
        ax_reg  <= ax_next;
        acc_reg <= acc_next;
        if (st_reg == w2s_pkg::ST_IDLE) begin
            pt_reg[0] <= sat_field(s_tdata[69:38]);
            pt_reg[1] <= sat_field(s_tdata[101:70]);
            pt_reg[2] <= sat_field(s_tdata[133:102]);
        end
        if (st_reg == w2s_pkg::ST_VP_ACC && k_reg == 2'd3) vp_reg[i_reg] <= sat_acc(vp_sum);
        if (st_reg == w2s_pkg::ST_CL_ACC && k_reg == 2'd2)
            clip_reg[i_reg[1:0]] <= sat_acc(cl_sum);
        if (st_reg == w2s_pkg::ST_DIV && dctl_out.done) begin
            if (ax_reg) ny_reg <= dquo;
            else nx_reg <= dquo;
        end
        if (st_reg == w2s_pkg::ST_SCR_MUL) begin
            prx_reg <= px;
            pry_reg <= py;
        end
        if (st_reg == w2s_pkg::ST_CHECK && reject) out_reg <= '0;
        if (st_reg == w2s_pkg::ST_SCR_WR) begin
            out_reg <= {7'd0, sat_out(hy), sat_out(hx), 1'b1};
        end
    end
endmodule

>>> hw/rtl/w2s_qmul.sv
// Registered signed fixed-point multiplier with floor shift and saturation.
module w2s_qmul #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [DATA_WIDTH-1:0] b,
    output logic signed [DATA_WIDTH-1:0] p
);
    localparam int PW = 2 * DATA_WIDTH;

    logic signed [PW-1:0]         prod_reg;
    logic signed [PW-1:0]         shifted;
    logic signed [DATA_WIDTH-1:0] vmax;
    logic signed [DATA_WIDTH-1:0] vmin;

    // Full product is registered before the shift and clamp.
    always_ff @(posedge aclk) begin
        prod_reg <= PW'(a) * PW'(b);
    end

    // Arithmetic shift floors; clamp to the word range.
    always_comb begin
        shifted = prod_reg >>> FRAC_BITS;
        vmax    = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        vmin    = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        if (shifted > PW'(vmax)) begin
            p = vmax;
        end else if (shifted < PW'(vmin)) begin
            p = vmin;
        end else begin
            p = shifted[DATA_WIDTH-1:0];
        end
    end
endmodule

>>> hw/rtl/w2s_div.sv
// Restoring divider: magnitude of a numerator over a positive divisor, one bit per cycle.
module w2s_div #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  w2s_pkg::div_ctl_t            ctl_in,
    output w2s_pkg::div_ctl_t            ctl_out,
    input  logic        [DATA_WIDTH-1:0] num,
    input  logic        [DATA_WIDTH-1:0] den,
    output logic        [DATA_WIDTH+1:0] quo
);
    // Quotient at most 1.5*2^FRAC_BITS, so it fits in FRAC_BITS+2 bits beside numerator.
    localparam int STEPS = DATA_WIDTH + FRAC_BITS;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int RW    = DATA_WIDTH + 1;

    logic [STEPS-1:0] sh_reg, sh_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [RW-1:0]    trial;

    // One shift-subtract step per cycle.
    always_comb begin
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[RW-2:0], sh_reg[STEPS-1]} - RW'(den);
        if (ctl_in.start) begin
            sh_next   = {num, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            cnt_next  = CW'(STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[RW-1]) begin
                rem_next = trial;
            end else begin
                rem_next = {rem_reg[RW-2:0], sh_reg[STEPS-1]};
            end
            sh_next  = {sh_reg[STEPS-2:0], ~trial[RW-1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign quo           = sh_reg[DATA_WIDTH+1:0];
    assign ctl_out.start = 1'b0;
    assign ctl_out.busy  = busy_reg;
    assign ctl_out.done  = done_reg;
endmodule

>>> hw/rtl/w2s_checker.sv
// Port-level checker for the projection block, bound to the top level.
module w2s_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    // A result word held back by the sink stays unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // An invisible point carries zero coordinates.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[64:1] == 64'd0)
        else $error("rejected point with nonzero coordinates");

    // Input is not taken while a result waits.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // Padding bits stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[71:65] == 7'd0)
        else $error("padding bits set");
endmodule

bind world_to_screen_projection_unit w2s_checker u_w2s_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
